>>> hw/rtl/bmprd_pkg.sv
// ----------------------------------------------------------------------------
// bmprd_pkg
// Shared types and constants of the 24-bit BMP stream reader.
// ----------------------------------------------------------------------------
package bmprd_pkg;

	localparam int MAX_WIDTH    = 4096;
	localparam int MAX_HEIGHT   = 4096;
	localparam int HEADER_BYTES = 54;

	// Byte offsets of the header fields that are used
	localparam logic [5:0] HDR_SIG0   = 6'd0;
	localparam logic [5:0] HDR_SIG1   = 6'd1;
	localparam logic [5:0] HDR_OFFS   = 6'd10;
	localparam logic [5:0] HDR_WIDTH  = 6'd18;
	localparam logic [5:0] HDR_HEIGHT = 6'd22;
	localparam logic [5:0] HDR_BPP    = 6'd28;
	localparam logic [5:0] HDR_COMP   = 6'd30;
	localparam logic [5:0] HDR_LAST   = 6'(HEADER_BYTES - 1);

	localparam logic [7:0]  SIG_B   = 8'h42;
	localparam logic [7:0]  SIG_M   = 8'h4D;
	localparam logic [15:0] BPP_RGB = 16'd24;

	// Queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Result kinds
	localparam logic [1:0] KIND_PIXEL  = 2'd0;
	localparam logic [1:0] KIND_HEADER = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	// Error codes
	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_SIGNATURE  = 3'd1;
	localparam logic [2:0] ERR_DEPTH      = 3'd2;
	localparam logic [2:0] ERR_COMPRESSED = 3'd3;
	localparam logic [2:0] ERR_OFFSET     = 3'd4;
	localparam logic [2:0] ERR_TRUNCATED  = 3'd5;
	localparam logic [2:0] ERR_TOO_LARGE  = 3'd6;

	// Channel order inside a pixel triple
	localparam logic [1:0] CH_BLUE  = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_RED   = 2'd2;

	typedef enum logic [1:0] {
		OP_DATA   = 2'd0,
		OP_HEADER = 2'd1,
		OP_ERROR  = 2'd2
	} op_t;

	// One entry of the queue from front to back
	typedef struct packed {
		op_t         op;
		logic [7:0]  data;
		logic        fin;
		logic [2:0]  code;
		logic [12:0] width;
		logic [12:0] height;
		logic        top_down;
	} q_item_t;

	// One result item
	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  error_code;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [11:0] column;
		logic [11:0] row;
		logic [12:0] image_width;
		logic [12:0] image_height;
		logic        top_down;
		logic        last_pixel;
	} result_t;

	// Queue handshake between modules
	typedef struct packed {
		logic push;
		logic pop;
	} q_ctrl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

>>> hw/rtl/bmprd_front.sv
// ----------------------------------------------------------------------------
// bmprd_front
// Header capture and check, forward seek to the pixel data, byte classing.
// ----------------------------------------------------------------------------
module bmprd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         file_byte,
	input  logic               first_byte,
	input  logic               final_byte,
	output logic               push,
	output bmprd_pkg::q_item_t item
);
	import bmprd_pkg::*;

	typedef enum logic [3:0] {
		FPH_HEADER = 4'b0001,
		FPH_SKIP   = 4'b0010,
		FPH_DATA   = 4'b0100,
		FPH_IDLE   = 4'b1000
	} fphase_t;

	fphase_t     phase_q, phase_e, phase_d;
	logic [31:0] pos_q, pos_e, pos_d;
	logic [7:0]  sig0_q, sig1_q;
	logic [31:0] offs_q, wraw_q, hraw_q, comp_q;
	logic [15:0] bpp_q;

	logic [5:0]  pos6;
	logic [5:0]  d_offs, d_width, d_height, d_bpp, d_comp;
	logic [31:0] hmag;
	logic        too_large, empty_img;

	assign phase_e = first_byte ? FPH_HEADER : phase_q;
	assign pos_e   = first_byte ? 32'd0 : pos_q;
	assign pos6    = pos_e[5:0];

	assign d_offs   = pos6 - HDR_OFFS;
	assign d_width  = pos6 - HDR_WIDTH;
	assign d_height = pos6 - HDR_HEIGHT;
	assign d_bpp    = pos6 - HDR_BPP;
	assign d_comp   = pos6 - HDR_COMP;

	assign hmag      = hraw_q[31] ? (32'd0 - hraw_q) : hraw_q;
	assign too_large = (wraw_q > 32'(MAX_WIDTH)) || (hmag > 32'(MAX_HEIGHT));
	assign empty_img = (wraw_q == 32'd0) || (hmag == 32'd0);

	always_comb begin
		phase_d       = phase_q;
		pos_d         = pos_q;
		push          = 1'b0;
		item.op       = OP_DATA;
		item.data     = file_byte;
		item.fin      = final_byte;
		item.code     = ERR_NONE;
		item.width    = 13'd0;
		item.height   = 13'd0;
		item.top_down = 1'b0;
		if (accept) begin
			phase_d = phase_e;
			pos_d   = pos_e;
			unique case (phase_e)
				FPH_HEADER: begin
					pos_d = pos_e + 32'd1;
					if (pos6 != HDR_LAST) begin
						if (final_byte) begin
							push      = 1'b1;
							item.op   = OP_ERROR;
							item.code = ERR_TRUNCATED;
							phase_d   = FPH_IDLE;
						end
					end else begin
						push    = 1'b1;
						item.op = OP_ERROR;
						phase_d = FPH_IDLE;
						if (sig0_q != SIG_B || sig1_q != SIG_M) begin
							item.code = ERR_SIGNATURE;
						end else if (bpp_q != BPP_RGB) begin
							item.code = ERR_DEPTH;
						end else if (comp_q != 32'd0) begin
							item.code = ERR_COMPRESSED;
						end else if (too_large) begin
							item.code = ERR_TOO_LARGE;
						end else if (offs_q < 32'(HEADER_BYTES)) begin
							item.code = ERR_OFFSET;
						end else if (!empty_img && final_byte) begin
							item.code = ERR_TRUNCATED;
						end else begin
							item.op       = OP_HEADER;
							item.width    = wraw_q[12:0];
							item.height   = hmag[12:0];
							item.top_down = hraw_q[31];
							if (!empty_img) begin
								phase_d = FPH_SKIP;
							end
						end
					end
				end
				FPH_SKIP: begin
					if (pos_e != offs_q) begin
						pos_d = pos_e + 32'd1;
						if (final_byte) begin
							push      = 1'b1;
							item.op   = OP_ERROR;
							item.code = ERR_TRUNCATED;
							phase_d   = FPH_IDLE;
						end
					end else begin
						push    = 1'b1;
						phase_d = FPH_DATA;
					end
				end
				FPH_DATA: begin
					push = 1'b1;
				end
				FPH_IDLE: begin
				end
				default: begin
					phase_d = FPH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= FPH_HEADER;
			pos_q   <= 32'd0;
		end else begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
		end
	end

	// Capture the used header fields, little-endian, lane by lane
	always_ff @(posedge clk) begin
		if (accept && phase_e == FPH_HEADER) begin
			if (pos6 == HDR_SIG0) sig0_q <= file_byte;
			if (pos6 == HDR_SIG1) sig1_q <= file_byte;
			if (d_offs < 6'd4)   offs_q[{d_offs[1:0], 3'b000} +: 8]   <= file_byte;
			if (d_width < 6'd4)  wraw_q[{d_width[1:0], 3'b000} +: 8]  <= file_byte;
			if (d_height < 6'd4) hraw_q[{d_height[1:0], 3'b000} +: 8] <= file_byte;
			if (d_bpp < 6'd2)    bpp_q[{d_bpp[0], 3'b000} +: 8]       <= file_byte;
			if (d_comp < 6'd4)   comp_q[{d_comp[1:0], 3'b000} +: 8]   <= file_byte;
		end
	end

endmodule

>>> hw/rtl/bmprd_fifo.sv
// ----------------------------------------------------------------------------
// bmprd_fifo
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module bmprd_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  bmprd_pkg::q_ctrl_t ctrl,
	input  bmprd_pkg::q_item_t wr_item,
	output bmprd_pkg::q_item_t rd_item,
	output bmprd_pkg::q_stat_t stat
);
	import bmprd_pkg::*;

	q_item_t            slot_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_push, do_pop;

	assign stat.full  = (count_q == QCNT_W'(QDEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = ctrl.push && !stat.full;
	assign do_pop     = ctrl.pop && !stat.empty;
	assign rd_item    = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= wr_item;
	end

endmodule

>>> hw/rtl/bmprd_back.sv
// ----------------------------------------------------------------------------
// bmprd_back
// Pixel assembly, padding drop, row numbering and the result register.
// ----------------------------------------------------------------------------
module bmprd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop,
	input  bmprd_pkg::q_item_t item,
	output logic               res_valid,
	input  logic               res_ready,
	output bmprd_pkg::result_t res
);
	import bmprd_pkg::*;

	logic        active_q, active_d;
	logic [12:0] width_q, width_d, height_q, height_d;
	logic        td_q, td_d;
	logic [11:0] col_q, col_d, row_q, row_d;
	logic [1:0]  ch_q, ch_d, pad_q, pad_d;
	logic [7:0]  blue_q, blue_d, green_q, green_d;

	logic        valid_q;
	result_t     res_q, res_d;
	logic        emit;

	logic [12:0] row_inc, col_inc, row_flip;
	logic        rows_finished;
	logic        done_n;

	assign row_inc       = {1'b0, row_q} + 13'd1;
	assign col_inc       = {1'b0, col_q} + 13'd1;
	assign row_flip      = height_q - 13'd1 - {1'b0, row_q};
	assign rows_finished = (row_inc >= height_q);

	always_comb begin
		active_d = active_q;
		width_d  = width_q;
		height_d = height_q;
		td_d     = td_q;
		col_d    = col_q;
		row_d    = row_q;
		ch_d     = ch_q;
		pad_d    = pad_q;
		blue_d   = blue_q;
		green_d  = green_q;
		emit     = 1'b0;
		done_n   = 1'b0;
		res_d    = '0;
		if (pop) begin
			case (item.op)
				OP_HEADER: begin
					width_d            = item.width;
					height_d           = item.height;
					td_d               = item.top_down;
					col_d              = 12'd0;
					row_d              = 12'd0;
					ch_d               = CH_BLUE;
					pad_d              = 2'd0;
					active_d           = (item.width != 13'd0) && (item.height != 13'd0);
					emit               = 1'b1;
					res_d.kind         = KIND_HEADER;
					res_d.image_width  = item.width;
					res_d.image_height = item.height;
					res_d.top_down     = item.top_down;
				end
				OP_ERROR: begin
					active_d         = 1'b0;
					emit             = 1'b1;
					res_d.kind       = KIND_ERROR;
					res_d.error_code = item.code;
				end
				OP_DATA: begin
					if (active_q) begin
						if (pad_q != 2'd0) begin
							// drop padding, close the row on its last byte
							pad_d = pad_q - 2'd1;
							if (pad_d == 2'd0) begin
								row_d  = row_inc[11:0];
								done_n = rows_finished;
							end
						end else if (ch_q == CH_BLUE) begin
							blue_d = item.data;
							ch_d   = CH_GREEN;
						end else if (ch_q == CH_GREEN) begin
							green_d = item.data;
							ch_d    = CH_RED;
						end else begin
							ch_d             = CH_BLUE;
							res_d.kind       = KIND_PIXEL;
							res_d.red        = item.data;
							res_d.green      = green_q;
							res_d.blue       = blue_q;
							res_d.column     = col_q;
							res_d.row        = td_q ? row_q : row_flip[11:0];
							res_d.top_down   = td_q;
							res_d.last_pixel = (row_inc == height_q) && (col_inc == width_q);
							emit             = 1'b1;
							if (col_inc >= width_q) begin
								col_d = 12'd0;
								pad_d = width_q[1:0];
								if (width_q[1:0] == 2'd0) begin
									row_d  = row_inc[11:0];
									done_n = rows_finished;
								end
							end else begin
								col_d = col_inc[11:0];
							end
						end
						if (done_n) begin
							active_d = 1'b0;
						end else if (item.fin) begin
							active_d         = 1'b0;
							emit             = 1'b1;
							res_d            = '0;
							res_d.kind       = KIND_ERROR;
							res_d.error_code = ERR_TRUNCATED;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			col_q    <= 12'd0;
			row_q    <= 12'd0;
			ch_q     <= CH_BLUE;
			pad_q    <= 2'd0;
			valid_q  <= 1'b0;
		end else begin
			active_q <= active_d;
			col_q    <= col_d;
			row_q    <= row_d;
			ch_q     <= ch_d;
			pad_q    <= pad_d;
			if (!valid_q || res_ready) begin
				valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		width_q  <= width_d;
		height_q <= height_d;
		td_q     <= td_d;
		blue_q   <= blue_d;
		green_q  <= green_d;
		if (!valid_q || res_ready) begin
			res_q <= res_d;
		end
	end

	assign res_valid = valid_q;
	assign res       = res_q;

endmodule

>>> hw/rtl/bmp_rgb24_stream_reader_top.sv
// ----------------------------------------------------------------------------
// bmp_rgb24_stream_reader_top
// Byte-stream reader for uncompressed 24-bit BMP files.
// ----------------------------------------------------------------------------
// Usage:
//   Feed the file one byte per transfer on the s_ channel, s_tuser high on
//   byte 0 of each file (restarts the parser) and s_tlast high on the last
//   byte. The m_ channel returns results: m_tuser gives the kind (pixel,
//   header accepted, error). A header result carries width, height and the
//   top-down flag; each pixel result carries R, G, B, column and top-down
//   row; m_tlast marks the final pixel of the image. An error ends the file:
//   later bytes are dropped until the next s_tuser.
// Throughput: one byte per cycle while the queue has room; the front captures
//   the header and seeks, a four-entry queue holds classified bytes, the back
//   assembles pixels into one output register.
// Path: the queue is written at the transfer edge; the output register loads
//   from the queue head when it is free or being drained, and drives m_tvalid.
// Reset: arst_n clears the parser to the header phase and empties the queue.
// Stall: while m_tready is low the result register holds; the queue fills
//   and s_tready drops once it holds four entries.
// ----------------------------------------------------------------------------
module bmp_rgb24_stream_reader_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] file_byte
	input  logic        s_tuser,  // [0] first_byte
	input  logic        s_tlast,  // final_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,  // [2:0] error_code, [10:3] red, [18:11] green,
	                              // [26:19] blue, [38:27] column, [50:39] row,
	                              // [63:51] image_width, [76:64] image_height,
	                              // [77] top_down, [79:78] zero
	output logic [1:0]  m_tuser,  // [1:0] kind
	output logic        m_tlast   // last_pixel
);
	import bmprd_pkg::*;

	logic    accept;
	logic    push;
	q_item_t front_item, back_item;
	q_ctrl_t q_ctrl;
	q_stat_t q_stat;
	result_t res;

	// Take a byte whenever the queue has room
	assign s_tready = !q_stat.full;
	assign accept   = s_tvalid && s_tready;

	bmprd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.file_byte  (s_tdata),
		.first_byte (s_tuser),
		.final_byte (s_tlast),
		.push       (push),
		.item       (front_item)
	);

	// Advance the queue when the output register is free or being drained
	assign q_ctrl.push = push;
	assign q_ctrl.pop  = !q_stat.empty && (!m_tvalid || m_tready);

	bmprd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (q_ctrl),
		.wr_item (front_item),
		.rd_item (back_item),
		.stat    (q_stat)
	);

	bmprd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop       (q_ctrl.pop),
		.item      (back_item),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	// Pack the result fields, error_code in the lowest bits
	assign m_tdata = {2'b00, res.top_down, res.image_height, res.image_width,
	                  res.row, res.column, res.blue, res.green, res.red,
	                  res.error_code};
	assign m_tuser = res.kind;
	assign m_tlast = res.last_pixel;

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 24-bit BMP stream reader. Whole files, both
// clean and broken, are sent byte by byte. An in-bench parser predicts every
// header, pixel and error result, and each returned transfer is checked
// against it field by field.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bmprd_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int RANDOM_BYTES = 200;
	localparam int CALM_BYTES   = 200;
	localparam int LONG_HOLD    = 240;
	localparam int MAX_REPORTS  = 40;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_SKIP,
		PH_PIXELS,
		PH_DONE
	} parse_phase_t;

	// One byte on its way into the reader
	typedef struct {
		logic [7:0] data;
		logic       first;
		logic       fin;
		bit         hold;   // offer only once every pending result is back
	} file_byte_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;
	logic        s_tuser  = 1'b0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	bmp_rgb24_stream_reader_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------
	// Parser mirror: follows the reader byte by byte
	// ------------------------------------------------------------------
	logic [7:0]   hdr_bytes [HEADER_BYTES];
	parse_phase_t parse_ph;
	logic [31:0]  byte_pos;
	logic [31:0]  offs_q;
	logic [31:0]  width_q;
	logic [31:0]  height_q;
	logic         td_q;
	logic [31:0]  col_cnt;
	logic [31:0]  row_cnt;
	logic [1:0]   chan;
	logic [1:0]   pad_left;
	logic [7:0]   blue_q;
	logic [7:0]   green_q;

	file_byte_t   byte_feed [$];        // bytes not yet offered
	result_t      pending_results [$];  // predicted, not yet returned
	logic [7:0]   img [$];              // file under construction
	int unsigned  img_w, img_h, img_offs;
	bit           hold_next;

	int unsigned  bytes_taken  = 0;
	int unsigned  results_seen = 0;
	int unsigned  calm_mark    = 32'hFFFF_FFFF;
	int unsigned  mismatches   = 0;
	int unsigned  cycles       = 0;

	function automatic void clear_parser();
		foreach (hdr_bytes[i])
			hdr_bytes[i] = '0;
		parse_ph = PH_HEADER;
		byte_pos = '0;
		offs_q   = '0;
		width_q  = '0;
		height_q = '0;
		td_q     = 1'b0;
		col_cnt  = '0;
		row_cnt  = '0;
		chan     = CH_BLUE;
		pad_left = '0;
		blue_q   = '0;
		green_q  = '0;
	endfunction

	function automatic logic [31:0] hdr_word(int at);
		return {hdr_bytes[at + 3], hdr_bytes[at + 2], hdr_bytes[at + 1], hdr_bytes[at]};
	endfunction

	function automatic result_t abort_file(logic [2:0] code);
		result_t r;
		r = '0;
		r.kind = KIND_ERROR;
		r.error_code = code;
		parse_ph = PH_DONE;
		return r;
	endfunction

	function automatic void next_row();
		row_cnt++;
		if (row_cnt >= height_q)
			parse_ph = PH_DONE;
	endfunction

	// Advance the mirror by one byte; returns 1 when the byte yields a result
	function automatic bit parse_byte(input logic [7:0] b, input logic first,
			input logic fin, output result_t res);
		logic [31:0] pos, wraw, hraw, hmag, offs, col, prow;
		res = '0;
		if (first)
			clear_parser();
		if (parse_ph == PH_HEADER) begin
			pos = byte_pos;
			if (pos < HEADER_BYTES)
				hdr_bytes[pos] = b;
			byte_pos = pos + 1;
			if (pos + 1 < HEADER_BYTES) begin
				if (fin) begin
					res = abort_file(ERR_TRUNCATED);
					return 1'b1;
				end
				return 1'b0;
			end
			wraw = hdr_word(HDR_WIDTH);
			hraw = hdr_word(HDR_HEIGHT);
			hmag = hraw[31] ? 32'd0 - hraw : hraw;
			offs = hdr_word(HDR_OFFS);
			if (hdr_bytes[HDR_SIG0] != SIG_B || hdr_bytes[HDR_SIG1] != SIG_M)
				res = abort_file(ERR_SIGNATURE);
			else if ({hdr_bytes[HDR_BPP + 1], hdr_bytes[HDR_BPP]} != BPP_RGB)
				res = abort_file(ERR_DEPTH);
			else if (hdr_word(HDR_COMP) != 0)
				res = abort_file(ERR_COMPRESSED);
			else if (wraw > MAX_WIDTH || hmag > MAX_HEIGHT)
				res = abort_file(ERR_TOO_LARGE);
			else if (offs < HEADER_BYTES)
				res = abort_file(ERR_OFFSET);
			else begin
				width_q  = wraw;
				height_q = hmag;
				td_q     = hraw[31];
				offs_q   = offs;
				// an empty image is complete with its header
				if (wraw == 0 || hmag == 0)
					parse_ph = PH_DONE;
				else if (fin) begin
					res = abort_file(ERR_TRUNCATED);
					return 1'b1;
				end else
					parse_ph = PH_SKIP;
				res.kind         = KIND_HEADER;
				res.image_width  = width_q[12:0];
				res.image_height = height_q[12:0];
				res.top_down     = td_q;
			end
			return 1'b1;
		end
		// forward-only seek to the pixel offset
		if (parse_ph == PH_SKIP) begin
			if (byte_pos != offs_q) begin
				byte_pos++;
				if (fin) begin
					res = abort_file(ERR_TRUNCATED);
					return 1'b1;
				end
				return 1'b0;
			end
			parse_ph = PH_PIXELS;
		end
		if (parse_ph != PH_PIXELS)
			return 1'b0;
		if (pad_left != 0) begin
			pad_left--;
			if (pad_left == 0)
				next_row();
			if (fin && parse_ph != PH_DONE) begin
				res = abort_file(ERR_TRUNCATED);
				return 1'b1;
			end
			return 1'b0;
		end
		if (chan == CH_BLUE || chan == CH_GREEN) begin
			if (chan == CH_BLUE) begin
				blue_q = b;
				chan = CH_GREEN;
			end else begin
				green_q = b;
				chan = CH_RED;
			end
			if (fin) begin
				res = abort_file(ERR_TRUNCATED);
				return 1'b1;
			end
			return 1'b0;
		end
		chan = CH_BLUE;
		col  = col_cnt;
		prow = td_q ? row_cnt : height_q - 1 - row_cnt;
		res.last_pixel = (row_cnt + 1 == height_q) && (col + 1 == width_q);
		col_cnt++;
		if (col_cnt >= width_q) begin
			col_cnt  = '0;
			pad_left = width_q[1:0];
			if (pad_left == 0)
				next_row();
		end
		if (fin && parse_ph != PH_DONE) begin
			res = abort_file(ERR_TRUNCATED);
			return 1'b1;
		end
		res.kind     = KIND_PIXEL;
		res.red      = b;
		res.green    = green_q;
		res.blue     = blue_q;
		res.column   = col[11:0];
		res.row      = prow[11:0];
		res.top_down = td_q;
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// File construction
	// ------------------------------------------------------------------
	task automatic put_word(int at, logic [31:0] v);
		img[at]     = v[7:0];
		img[at + 1] = v[15:8];
		img[at + 2] = v[23:16];
		img[at + 3] = v[31:24];
	endtask

	// Clean 24-bit header with random filler in the unused fields
	task automatic build_bmp(logic [31:0] wv, logic [31:0] hv, logic [31:0] offs);
		img.delete();
		repeat (HEADER_BYTES)
			img.push_back(8'($urandom));
		img[HDR_SIG0] = SIG_B;
		img[HDR_SIG1] = SIG_M;
		put_word(HDR_OFFS, offs);
		put_word(HDR_WIDTH, wv);
		put_word(HDR_HEIGHT, hv);
		img[HDR_BPP]     = BPP_RGB[7:0];
		img[HDR_BPP + 1] = BPP_RGB[15:8];
		put_word(HDR_COMP, 32'd0);
		img_w    = wv;
		img_h    = hv[31] ? 32'd0 - hv : hv;
		img_offs = offs;
	endtask

	task automatic add_junk(int unsigned n);
		repeat (n)
			img.push_back(8'($urandom));
	endtask

	// Gap up to the pixel offset, then every row with its padding
	task automatic add_body();
		add_junk(img_offs - HEADER_BYTES);
		repeat (img_h)
			add_junk(3 * img_w + (img_w & 3));
	endtask

	// Queue the first cut bytes of the file, fin on the last one if asked
	task automatic send_file(int unsigned cut, bit fin, bit with_first);
		int unsigned n;
		file_byte_t  fb;
		n = (cut > img.size()) ? img.size() : cut;
		for (int unsigned i = 0; i < n; i++) begin
			fb.data  = img[i];
			fb.first = with_first && (i == 0);
			fb.fin   = fin && (i == n - 1);
			fb.hold  = hold_next && (i == 0);
			byte_feed.push_back(fb);
		end
		hold_next = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Mismatch reporting
	// ------------------------------------------------------------------
	task automatic report(string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("MISMATCH @%0t result %0d: %s", $realtime, results_seen, msg);
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	// ------------------------------------------------------------------
	// Driver: offer queued bytes, predict each accepted transfer
	// ------------------------------------------------------------------
	file_byte_t  drv_item;
	result_t     drv_res;
	int unsigned gap_left  = 0;
	int unsigned src_rate  = 0;
	int unsigned src_timer = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= 1'b0;
			s_tlast  <= 1'b0;
		end else begin
			// retune the idle rate now and then; rate zero gives clean stretches
			if (src_timer == 0) begin
				src_rate  = $urandom_range(0, 3);
				src_timer = $urandom_range(50, 200);
			end else
				src_timer--;

			if (s_tvalid && s_tready) begin
				if (parse_byte(s_tdata, s_tuser, s_tlast, drv_res))
					pending_results.push_back(drv_res);
				bytes_taken++;
			end

			// hold the current byte until it is taken
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (bytes_taken < calm_mark && src_rate != 0 &&
						$urandom_range(1, 16) <= 2 * src_rate) begin
					gap_left = $urandom_range(0, 7);
					s_tvalid <= 1'b0;
				end else if (byte_feed.size() != 0 &&
						!(byte_feed[0].hold && pending_results.size() != 0)) begin
					drv_item = byte_feed.pop_front();
					s_tdata  <= drv_item.data;
					s_tuser  <= drv_item.first;
					s_tlast  <= drv_item.fin;
					s_tvalid <= 1'b1;
				end else
					s_tvalid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: check each result transfer, throttle m_tready
	// ------------------------------------------------------------------
	result_t     mon_got;
	result_t     mon_want;
	int unsigned stall_left = 0;
	int unsigned snk_rate   = 0;
	int unsigned snk_timer  = 0;
	int unsigned long_holds = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (snk_timer == 0) begin
				snk_rate  = $urandom_range(0, 3);
				snk_timer = $urandom_range(50, 200);
			end else
				snk_timer--;

			if (m_tvalid && m_tready) begin
				results_seen++;
				mon_got.kind         = m_tuser;
				mon_got.error_code   = m_tdata[2:0];
				mon_got.red          = m_tdata[10:3];
				mon_got.green        = m_tdata[18:11];
				mon_got.blue         = m_tdata[26:19];
				mon_got.column       = m_tdata[38:27];
				mon_got.row          = m_tdata[50:39];
				mon_got.image_width  = m_tdata[63:51];
				mon_got.image_height = m_tdata[76:64];
				mon_got.top_down     = m_tdata[77];
				mon_got.last_pixel   = m_tlast;
				if (pending_results.size() == 0)
					report("result with nothing expected");
				else begin
					mon_want = pending_results.pop_front();
					check_field("kind", 32'(mon_got.kind), 32'(mon_want.kind));
					check_field("error_code", 32'(mon_got.error_code),
						32'(mon_want.error_code));
					check_field("red", 32'(mon_got.red), 32'(mon_want.red));
					check_field("green", 32'(mon_got.green), 32'(mon_want.green));
					check_field("blue", 32'(mon_got.blue), 32'(mon_want.blue));
					check_field("column", 32'(mon_got.column), 32'(mon_want.column));
					check_field("row", 32'(mon_got.row), 32'(mon_want.row));
					check_field("image_width", 32'(mon_got.image_width),
						32'(mon_want.image_width));
					check_field("image_height", 32'(mon_got.image_height),
						32'(mon_want.image_height));
					check_field("top_down", 32'(mon_got.top_down),
						32'(mon_want.top_down));
					check_field("last_pixel", 32'(mon_got.last_pixel),
						32'(mon_want.last_pixel));
				end
			end

			// two long holds while results stream, so the input side backs up
			if (stall_left != 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if ((long_holds == 0 && results_seen >= 20) ||
					(long_holds == 1 && results_seen >= 60)) begin
				long_holds++;
				stall_left = LONG_HOLD - 1;
				m_tready <= 1'b0;
			end else if (bytes_taken < calm_mark && snk_rate != 0 &&
					$urandom_range(1, 16) <= 2 * snk_rate) begin
				stall_left = $urandom_range(0, 7);
				m_tready <= 1'b0;
			end else
				m_tready <= 1'b1;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus and end of test
	// ------------------------------------------------------------------
	initial begin : stimulus
		int unsigned w, h, offs, sel, start;
		logic [31:0] hv;

		clear_parser();
		hold_next = 1'b0;

		// clean files: padding of one, two, three and none; top-down and bottom-up
		build_bmp(1, 3, 54);
		add_body();
		send_file(img.size(), 1, 0);    // no restart mark needed straight after reset
		build_bmp(2, 2, 54);
		add_body();
		send_file(img.size(), 1, 1);
		build_bmp(4, -32'sd1, 54);
		add_body();
		add_junk(3);                    // trailing bytes after the image
		send_file(img.size(), 1, 1);
		build_bmp(3, -32'sd2, 60);      // pixel data behind a gap
		add_body();
		send_file(img.size(), 1, 1);

		// header rejections, in check order
		build_bmp(2, 1, 54);
		img[HDR_SIG0] = ~SIG_B;
		add_junk(4);
		send_file(img.size(), 1, 1);
		build_bmp(2, 1, 54);
		img[HDR_SIG1] = SIG_B;
		send_file(HEADER_BYTES, 0, 1);
		build_bmp(2, 1, 54);
		img[HDR_BPP] = 8'd32;
		send_file(HEADER_BYTES, 1, 1);
		build_bmp(2, 1, 54);
		img[HDR_BPP + 1] = 8'h01;
		send_file(HEADER_BYTES, 1, 1);
		build_bmp(2, 1, 54);
		put_word(HDR_COMP, 32'd1);
		send_file(HEADER_BYTES, 1, 1);
		build_bmp(2, 1, 54);
		put_word(HDR_COMP, 32'h8000_0000);
		send_file(HEADER_BYTES, 1, 1);
		build_bmp(32'h8000_0000, 1, 54);   // negative width
		send_file(HEADER_BYTES, 1, 1);
		build_bmp(MAX_WIDTH + 1, 1, 54);
		send_file(HEADER_BYTES, 1, 1);
		build_bmp(2, -(MAX_HEIGHT + 1), 54);
		send_file(HEADER_BYTES, 1, 1);
		build_bmp(2, 32'h8000_0000, 54);
		send_file(HEADER_BYTES, 1, 1);
		build_bmp(2, 2, HEADER_BYTES - 1);
		send_file(HEADER_BYTES, 1, 1);
		build_bmp(2, 2, 0);
		send_file(HEADER_BYTES, 1, 1);

		// empty images: header result only, later bytes dropped
		build_bmp(0, 5, 54);
		add_junk(5);
		send_file(img.size(), 1, 1);
		build_bmp(3, 0, 54);
		send_file(HEADER_BYTES, 1, 1);

		// truncation at each stage
		build_bmp(2, 2, 54);
		send_file(1, 1, 1);                // one-byte file
		build_bmp(2, 2, 54);
		send_file(11, 1, 1);               // inside the header
		build_bmp(2, 2, 54);
		send_file(HEADER_BYTES, 1, 1);     // on the last header byte
		build_bmp(2, 1, 70);
		add_body();
		send_file(60, 1, 1);               // inside the gap
		build_bmp(2, 1, 54);
		add_body();
		send_file(56, 1, 1);               // on a green byte
		build_bmp(3, 1, 54);
		add_body();
		send_file(img.size() - 1, 1, 1);   // on padding before the last byte
		build_bmp(1, 2, 54);
		add_body();
		send_file(img.size() - 1, 1, 1);   // on the last red, padding still due
		build_bmp(2, 2, 54);
		add_body();
		send_file(40, 0, 1);               // abandoned: next file restarts

		// a full file, offered only after the pipeline has drained
		hold_next = 1'b1;
		build_bmp(5, 2, 54);
		add_body();
		send_file(img.size(), 1, 1);
		// largest images, cut short
		build_bmp(MAX_WIDTH, -MAX_HEIGHT, 54);
		add_junk(30);
		send_file(img.size(), 0, 1);
		build_bmp(1, MAX_HEIGHT, 54);
		add_junk(9);
		send_file(img.size(), 1, 1);
		build_bmp(1, 1, 32'hFFFF_FFF0);    // far seek, file ends first
		add_junk(12);
		send_file(img.size(), 1, 1);

		// random files, mostly well formed
		start = byte_feed.size();
		while (byte_feed.size() - start < RANDOM_BYTES) begin
			w    = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 9);
			h    = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 4);
			if ($urandom_range(0, 15) == 0)
				w = $urandom_range(10, 40);
			hv   = $urandom_range(0, 1) ? 32'd0 - h : h;
			offs = ($urandom_range(0, 3) == 0) ? 54 + $urandom_range(1, 24) : 54;
			hold_next = ($urandom_range(0, 9) == 0);
			build_bmp(w, hv, offs);
			sel = $urandom_range(0, 99);
			if (sel < 70) begin
				add_body();
				if ($urandom_range(0, 3) == 0)
					add_junk($urandom_range(1, 5));
				send_file(img.size(), 1, $urandom_range(0, 7) != 0);
			end else if (sel < 94) begin
				case (sel % 6)
					0: img[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
					1: img[HDR_BPP + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
					2: put_word(HDR_COMP, $urandom_range(1, 32'hFFFF_FFFF));
					3: put_word(HDR_WIDTH, $urandom_range(MAX_WIDTH + 1, 32'hFFFF_FFFF));
					4: put_word(HDR_HEIGHT, $urandom_range(0, 1) ?
						$urandom_range(MAX_HEIGHT + 1, 32'h7FFF_FFFF) :
						32'd0 - $urandom_range(MAX_HEIGHT + 1, 32'h8000_0000));
					default: put_word(HDR_OFFS, $urandom_range(0, HEADER_BYTES - 1));
				endcase
				add_junk(6);
				send_file(HEADER_BYTES + $urandom_range(0, 6), $urandom_range(0, 1), 1);
			end else begin
				add_body();
				send_file($urandom_range(1, img.size() - 1), sel < 98, 1);
			end
			// stray bytes between files; dropped unless the file was left open
			if ($urandom_range(0, 4) == 0) begin
				img.delete();
				add_junk($urandom_range(1, 4));
				send_file(img.size(), $urandom_range(0, 1), 0);
			end
		end
		calm_mark = byte_feed.size() - CALM_BYTES;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (byte_feed.size() != 0 || s_tvalid)
			@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/bmprd_pkg.sv
hw/rtl/bmprd_front.sv
hw/rtl/bmprd_fifo.sv
hw/rtl/bmprd_back.sv
hw/rtl/bmp_rgb24_stream_reader_top.sv
sim/tb_top.sv
